>>> design/assert_macros.svh
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_IMPL(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

>>> design/ats_pkg.sv
// ----------------------------------------------------------------------------
// ats_pkg: shared types and constants for the alarm table scheduler
// Request layout, result kinds and default sizes.
// ----------------------------------------------------------------------------
package ats_pkg;
  localparam int unsigned AlarmCountDef = 8;
  localparam int unsigned EventBitsDef  = 8;
  localparam int unsigned DelayW        = 31;
  localparam int unsigned TimeW         = 32;
  localparam int unsigned AuxW          = 32;
  localparam int unsigned IdW           = 8;
  localparam int unsigned SignBit       = 31;
  localparam int unsigned QueueDepth    = 2;

  localparam logic       OP_PROGRAM = 1'b0;
  localparam logic       OP_CHECK   = 1'b1;
  localparam logic [1:0] KIND_FIRED = 2'd0;
  localparam logic [1:0] KIND_OK    = 2'd1;
  localparam logic [1:0] KIND_FULL  = 2'd2;

  // classified request passed from front to back
  typedef struct packed {
    logic              check;
    logic              cancel;
    logic [IdW-1:0]    event_id;
    logic              periodic;
    logic [DelayW-1:0] delay_ms;
    logic [AuxW-1:0]   aux_data;
    logic [TimeW-1:0]  now_ms;
  } req_t;

  typedef struct packed {
    logic [1:0]     kind;
    logic [IdW-1:0] event_id;
    logic [AuxW-1:0] aux;
    logic           last;
  } res_t;
endpackage

>>> design/alarm_table_scheduler.sv
// ----------------------------------------------------------------------------
// alarm_table_scheduler: software-style alarm table
// Accepts program/cancel and check requests; emits status and fired alarms.
// ----------------------------------------------------------------------------
// The back end walks one slot a cycle unless a due alarm waits for the output
// register, and it cannot take a new request before it is through with the last
// one. A two-entry queue holds requests while it walks. Reset (rst, synchronous)
// empties table and queue.
`include "assert_macros.svh"
module alarm_table_scheduler #(
  parameter int unsigned ALARM_COUNT = ats_pkg::AlarmCountDef,
  parameter int unsigned EVENT_BITS  = ats_pkg::EventBitsDef
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // tdata: event_id[7:0], periodic[8], delay_ms[39:9], aux_data[71:40],
  //        now_ms[103:72]
  input  logic [103:0]  s_tdata,
  // tuser: operation
  input  logic          s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  // tdata: fired_event[7:0], fired_aux[39:8]
  output logic [39:0]   m_tdata,
  // tuser: kind
  output logic [1:0]    m_tuser,
  output logic          m_tlast
);
  logic q_valid, q_ready, busy;
  ats_pkg::req_t q_req;
  ats_pkg::res_t res;

  ats_front #(.EVENT_BITS(EVENT_BITS)) u_front (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready),
    .operation(s_tuser), .event_id(s_tdata[7:0]), .periodic(s_tdata[8]),
    .delay_ms(s_tdata[39:9]), .aux_data(s_tdata[71:40]), .now_ms(s_tdata[103:72]),
    .q_valid, .q_ready, .q_req
  );

  ats_back #(.ALARM_COUNT(ALARM_COUNT)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_req,
    .res_valid(m_tvalid), .res_ready(m_tready), .res, .busy
  );

  assign m_tdata = {res.aux, res.event_id};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

  `ASSERT_NEVER(a_status_last, m_tvalid && (m_tuser != ats_pkg::KIND_FIRED) && !m_tlast, "status without last")
  `ASSERT_NEVER(a_bad_kind, m_tvalid && (m_tuser == 2'd3), "invalid kind")
  `ASSERT_IMPL(a_take_when_busy, (q_valid && q_ready) |=> busy, "back end idle after take")
  `ASSERT_NEVER(a_fired_aux, m_tvalid && (m_tuser != ats_pkg::KIND_FIRED) && (res.aux != '0), "status aux")
endmodule

>>> design/ats_front.sv
// ----------------------------------------------------------------------------
// ats_front: request intake and classification
// Decodes the input request and holds it in a short queue for the back end.
// ----------------------------------------------------------------------------
module ats_front #(
  parameter int unsigned EVENT_BITS = ats_pkg::EventBitsDef
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 operation,
  input  logic [ats_pkg::IdW-1:0]    event_id,
  input  logic                 periodic,
  input  logic [ats_pkg::DelayW-1:0] delay_ms,
  input  logic [ats_pkg::AuxW-1:0]   aux_data,
  input  logic [ats_pkg::TimeW-1:0]  now_ms,
  output logic                 q_valid,
  input  logic                 q_ready,
  output ats_pkg::req_t        q_req
);
  localparam logic [ats_pkg::IdW-1:0] IdMask =
    ats_pkg::IdW'((9'd1 << EVENT_BITS) - 9'd1);

  ats_pkg::req_t slot0, slot1, cls;
  logic [1:0] fill;

  always_comb begin
    cls.check    = (operation == ats_pkg::OP_CHECK);
    cls.event_id = event_id & IdMask;
    cls.periodic = periodic;
    cls.delay_ms = delay_ms;
    cls.aux_data = aux_data;
    cls.now_ms   = now_ms;
    cls.cancel   = !cls.check && (delay_ms == '0) && !periodic;
  end

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_req    = slot0;

  wire push = in_valid && in_ready;
  wire pop  = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
    if (pop) begin
      slot0 <= (fill == 2'd2) ? slot1 : cls;
      if (push) slot1 <= cls;
    end else if (push) begin
      if (fill == 2'd0) slot0 <= cls;
      else slot1 <= cls;
    end
  end
endmodule

>>> design/ats_back.sv
// ----------------------------------------------------------------------------
// ats_back: table sequencer
// Walks the alarm slots one per cycle (a check may stall on output) to program, cancel or check alarms.
// ----------------------------------------------------------------------------
module ats_back #(
  parameter int unsigned ALARM_COUNT = ats_pkg::AlarmCountDef
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  ats_pkg::req_t q_req,
  output logic          res_valid,
  input  logic          res_ready,
  output ats_pkg::res_t res,
  output logic          busy
);
  localparam int unsigned IW = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;
  localparam int unsigned CW = $clog2(ALARM_COUNT + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_SCAN = 4'b0010, S_EMIT = 4'b0100, S_DONE = 4'b1000
  } state_t;

  state_t state;
  ats_pkg::req_t req;
  logic [ALARM_COUNT-1:0] valid;
  logic [ats_pkg::IdW-1:0]    ev_r  [ALARM_COUNT];
  logic [ats_pkg::AuxW-1:0]   aux_r [ALARM_COUNT];
  logic [ats_pkg::TimeW-1:0]  st_r  [ALARM_COUNT];
  logic [ats_pkg::DelayW-1:0] dl_r  [ALARM_COUNT];
  logic [ALARM_COUNT-1:0]     rp_r;
  logic [CW-1:0] idx;
  logic [CW-1:0] free_idx;
  logic          free_ok;
  logic          pend;     // a result held back; a fired one waits to learn if it is the last
  ats_pkg::res_t pend_res;
  logic          out_v;
  ats_pkg::res_t out_r;

  wire [IW-1:0] i = idx[IW-1:0];
  wire [ats_pkg::TimeW-1:0] elapsed = req.now_ms - st_r[i];
  wire due = valid[i] && !elapsed[ats_pkg::SignBit] &&
             ({1'b0, elapsed[ats_pkg::SignBit-1:0]} >= {1'b0, dl_r[i]});
  wire hit = valid[i] && (ev_r[i] == req.event_id);
  wire out_free = !out_v || res_ready;
  wire at_end = (idx == CW'(ALARM_COUNT - 1));
  // output register takes the pending result this cycle
  wire out_load = ((state == S_SCAN) && req.check && due && pend && out_free) ||
                  ((state == S_EMIT) && pend && out_free);

  assign q_ready   = (state == S_IDLE);
  assign res_valid = out_v;
  assign res       = out_r;
  assign busy      = (state != S_IDLE) || out_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      out_v <= 1'b0;
      pend  <= 1'b0;
    end else begin
      if (out_load) out_v <= 1'b1;
      else if (res_ready) out_v <= 1'b0;
      unique case (state)
        S_IDLE: if (q_valid) begin
          req      <= q_req;
          idx      <= '0;
          free_ok  <= 1'b0;
          pend     <= 1'b0;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          if (req.check) begin
            // a due alarm waits until the output register can take the older one
            if (due && pend && !out_free) begin
              state <= S_SCAN;
            end else begin
              if (due) begin
                if (pend) begin
                  out_r <= pend_res;
                end
                pend <= 1'b1;
                pend_res <= '{kind: ats_pkg::KIND_FIRED, event_id: ev_r[i],
                              aux: aux_r[i], last: 1'b0};
                if (rp_r[i]) st_r[i] <= req.now_ms;
                else valid[i] <= 1'b0;
              end
              if (at_end) state <= S_EMIT;
              else idx <= idx + 1'b1;
            end
          end else if (hit) begin
            if (req.cancel) begin
              valid[i] <= 1'b0;
            end else begin
              dl_r[i] <= req.delay_ms;
              st_r[i] <= req.now_ms;
            end
            pend_res <= '{kind: ats_pkg::KIND_OK, event_id: req.event_id,
                          aux: '0, last: 1'b1};
            pend    <= 1'b1;
            free_ok <= 1'b0;
            state   <= S_EMIT;
          end else begin
            if (!valid[i]) begin
              free_ok  <= 1'b1;
              free_idx <= idx;
            end
            if (at_end) begin
              state <= S_DONE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_DONE: begin
          // insert into highest free slot or report full; cancel of an absent id reports ok
          if (req.cancel) begin
            pend_res <= '{kind: ats_pkg::KIND_OK, event_id: req.event_id,
                          aux: '0, last: 1'b1};
          end else if (free_ok || !valid[i]) begin
            if (!valid[i]) free_idx <= idx;
            pend_res <= '{kind: ats_pkg::KIND_OK, event_id: req.event_id,
                          aux: '0, last: 1'b1};
          end else begin
            pend_res <= '{kind: ats_pkg::KIND_FULL, event_id: req.event_id,
                          aux: '0, last: 1'b1};
          end
          pend  <= 1'b1;
          if (!req.cancel && (free_ok || !valid[i])) begin
            idx   <= valid[i] ? free_idx : idx;
            state <= S_EMIT;
            free_ok <= 1'b1;
          end else begin
            free_ok <= 1'b0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (free_ok && !req.check) begin
            valid[idx[IW-1:0]] <= 1'b1;
            ev_r[idx[IW-1:0]]  <= req.event_id;
            aux_r[idx[IW-1:0]] <= req.aux_data;
            dl_r[idx[IW-1:0]]  <= req.delay_ms;
            st_r[idx[IW-1:0]]  <= req.now_ms;
            rp_r[idx[IW-1:0]]  <= req.periodic;
            free_ok <= 1'b0;
          end
          if (!pend) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_r <= '{kind: pend_res.kind, event_id: pend_res.event_id,
                       aux: pend_res.aux, last: 1'b1};
            pend  <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
